/* design/multi_client_file_lock_manager_defines.svh */
// Assertion macros used by the lock manager checker.
// No dependencies; include once per file that asserts.
`ifndef MULTI_CLIENT_FILE_LOCK_MANAGER_DEFINES_SVH
`define MULTI_CLIENT_FILE_LOCK_MANAGER_DEFINES_SVH

// Concurrent check, quiet while reset is low.
`define FLM_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on the lock manager clock and reset.
`define FLM_ASSERT(label, prop, msg) \
    `FLM_ASSERT_RUN(label, i_clk, i_rst_n, prop, msg)

`endif

/* design/flm_pkg.sv */
// Shared types, level codes and status codes for the file lock manager.
// No dependencies.
`timescale 1ns / 1ps

package flm_pkg;

    localparam int DEF_NUM_CLIENTS = 8;

    localparam logic [2:0] LV_NONE     = 3'd0;
    localparam logic [2:0] LV_SHARED   = 3'd1;
    localparam logic [2:0] LV_RESERVED = 3'd2;
    localparam logic [2:0] LV_PENDING  = 3'd3;
    localparam logic [2:0] LV_EXCL     = 3'd4;

    localparam int BIT_SHARED   = 0;
    localparam int BIT_RESERVED = 1;
    localparam int BIT_PENDING  = 2;
    localparam int BIT_EXCL     = 3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BUSY    = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;

    localparam logic OP_RAISE = 1'b0;
    localparam logic OP_LOWER = 1'b1;

    localparam logic [3:0] RCNT_MAX = 4'hF;

    typedef struct packed {
        logic [2:0] client;
        logic       operation;
        logic [2:0] level;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] level_now;
        logic       reserved_held;
    } t_rsp;

    // Global lock state shared by all clients.
    typedef struct packed {
        logic [3:0] held;
        logic [3:0] rcnt;
    } t_lock_state;

endpackage

/* design/flm_level_store.sv */
// Per-client lock level memory with registered read and write-first bypass.
// Depends on flm_pkg.
`timescale 1ns / 1ps

module flm_level_store
    import flm_pkg::*;
#(
    parameter int NUM_CLIENTS = DEF_NUM_CLIENTS,
    localparam int AW = $clog2(NUM_CLIENTS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic          i_rd_in_range,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [2:0]    i_wr_data,
    output logic [2:0]    o_rd_data
);

    logic [2:0]             r_mem [NUM_CLIENTS];
    logic [NUM_CLIENTS-1:0] r_valid;
    logic [2:0]             r_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Bypass the word being written so a back-to-back request sees it.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (!i_rd_in_range) begin
                r_rd <= LV_NONE;
            end else if (i_wr_en && i_wr_addr == i_rd_addr) begin
                r_rd <= i_wr_data;
            end else if (r_valid[i_rd_addr]) begin
                r_rd <= r_mem[i_rd_addr];
            end else begin
                r_rd <= LV_NONE;
            end
        end
    end

    assign o_rd_data = r_rd;

endmodule

/* design/flm_lock_logic.sv */
// Combinational lock transition: raise or lower one client's level.
// Depends on flm_pkg.
`timescale 1ns / 1ps

module flm_lock_logic
    import flm_pkg::*;
(
    input  logic        i_in_range,
    input  logic        i_op,
    input  logic [2:0]  i_cur,
    input  logic [2:0]  i_tgt,
    input  t_lock_state i_state,
    output t_lock_state o_state,
    output logic        o_wr_en,
    output t_rsp        o_rsp
);

    always_comb begin
        logic [3:0] h;
        logic [3:0] c;
        logic [2:0] newl;
        logic [1:0] st;
        logic       res;
        logic       got_pend;

        h        = i_state.held;
        c        = i_state.rcnt;
        newl     = i_cur;
        st       = ST_OK;
        res      = 1'b1;
        got_pend = 1'b0;

        if (!i_in_range) begin
            newl = LV_NONE;
            st   = ST_ILLEGAL;
        end else if (i_op == OP_RAISE) begin
            if (i_tgt > LV_EXCL) begin
                st = ST_ILLEGAL;
            end else if (i_cur >= i_tgt) begin
                st = ST_OK;
            end else if ((i_cur == LV_NONE && i_tgt != LV_SHARED) || i_tgt == LV_PENDING
                         || (i_tgt == LV_RESERVED && i_cur != LV_SHARED)) begin
                st = ST_ILLEGAL;
            end else begin
                if (i_cur == LV_NONE || (i_tgt == LV_EXCL && i_cur == LV_RESERVED)) begin
                    res          = !h[BIT_PENDING];
                    h[BIT_PENDING] = 1'b1;
                    got_pend     = res;
                end
                if (i_tgt == LV_SHARED && res) begin
                    if (c != RCNT_MAX) begin
                        c = c + 4'd1;
                    end
                    h[BIT_SHARED] = 1'b1;
                    newl          = LV_SHARED;
                end
                if (i_tgt == LV_RESERVED && res) begin
                    res = !h[BIT_RESERVED];
                    h[BIT_RESERVED] = 1'b1;
                    if (res) begin
                        newl = LV_RESERVED;
                    end
                end
                if (i_tgt == LV_EXCL && res) begin
                    // Pending stays held while exclusive is tried.
                    newl     = LV_PENDING;
                    got_pend = 1'b0;
                    res      = !h[BIT_EXCL];
                    h[BIT_EXCL] = 1'b1;
                    if (res) begin
                        newl = LV_EXCL;
                    end
                end
                if (got_pend && i_tgt == LV_SHARED) begin
                    h[BIT_PENDING] = 1'b0;
                end
                st = res ? ST_OK : ST_BUSY;
            end
        end else begin
            if (i_tgt > LV_SHARED) begin
                st = ST_ILLEGAL;
            end else if (i_cur > i_tgt) begin
                if (i_cur >= LV_EXCL) begin
                    h[BIT_EXCL] = 1'b0;
                end
                if (i_cur >= LV_RESERVED) begin
                    h[BIT_RESERVED] = 1'b0;
                end
                if (i_tgt == LV_NONE) begin
                    if (c != 4'd0) begin
                        c = c - 4'd1;
                    end
                    if (c == 4'd0) begin
                        h[BIT_SHARED] = 1'b0;
                    end
                end
                if (i_cur >= LV_PENDING) begin
                    h[BIT_PENDING] = 1'b0;
                end
                newl = i_tgt;
            end
        end

        o_state.held        = h;
        o_state.rcnt        = c;
        o_wr_en             = i_in_range;
        o_rsp.status        = st;
        o_rsp.level_now     = newl;
        o_rsp.reserved_held = (i_in_range && newl >= LV_RESERVED) || h[BIT_RESERVED];
    end

endmodule

/* design/multi_client_file_lock_manager.sv */
// Five-level file lock manager: request register, level memory, result register.
// Requests are held in the request register, results in the result register.
// Throughput: one request per cycle unless a stalled result blocks the pipe; the
// level memory bypass keeps back-to-back requests of one client exact.
// Reset (synchronous, active low) drops all locks, held bits and reader count.
// Depends on flm_pkg, flm_level_store and flm_lock_logic.
`timescale 1ns / 1ps

module multi_client_file_lock_manager
    import flm_pkg::*;
#(
    parameter int NUM_CLIENTS = DEF_NUM_CLIENTS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int AW = $clog2(NUM_CLIENTS);
    localparam int IW = (AW > 3) ? AW : 3;

    logic          accept;
    logic          fire;
    logic [IW-1:0] client_ext;
    logic          in_range;

    logic          r_s1_vld;
    t_req          r_s1_req;
    logic          r_s1_inr;
    logic [AW-1:0] r_s1_idx;

    t_lock_state   r_state;
    t_lock_state   n_state;
    logic          wr_en;
    t_rsp          n_rsp;
    logic [2:0]    cur_level;

    logic          r_out_vld;
    t_rsp          r_out;

    assign client_ext  = IW'(i_req.client);
    assign in_range    = {1'b0, client_ext} < (IW + 1)'(NUM_CLIENTS);
    assign fire        = r_s1_vld && (!r_out_vld || i_rsp_ready);
    assign o_req_ready = !r_s1_vld || fire;
    assign accept      = i_req_valid && o_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (fire) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_req <= i_req;
            r_s1_inr <= in_range;
            r_s1_idx <= client_ext[AW-1:0];
        end
    end

    flm_level_store #(
        .NUM_CLIENTS(NUM_CLIENTS)
    ) u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_en       (accept),
        .i_rd_in_range (in_range),
        .i_rd_addr     (client_ext[AW-1:0]),
        .i_wr_en       (fire && wr_en),
        .i_wr_addr     (r_s1_idx),
        .i_wr_data     (n_rsp.level_now),
        .o_rd_data     (cur_level)
    );

    flm_lock_logic u_logic (
        .i_in_range (r_s1_inr),
        .i_op       (r_s1_req.operation),
        .i_cur      (cur_level),
        .i_tgt      (r_s1_req.level),
        .i_state    (r_state),
        .o_state    (n_state),
        .o_wr_en    (wr_en),
        .o_rsp      (n_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    // Hold the result word until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_rsp;
        end
    end

    assign o_rsp_valid = r_out_vld;
    assign o_rsp       = r_out;

endmodule

/* design/flm_checker.sv */
// Port-level checks for the lock manager, bound to the top level.
// Depends on flm_pkg and multi_client_file_lock_manager_defines.svh.
`timescale 1ns / 1ps
`include "multi_client_file_lock_manager_defines.svh"

module flm_checker
    import flm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_ready,
    input t_req i_req,
    input logic o_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp o_rsp
);

    `FLM_ASSERT(a_rsp_hold, o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp), "result word changed while stalled")
    `FLM_ASSERT(a_rsv_level, o_rsp_valid && o_rsp.level_now >= LV_RESERVED |-> o_rsp.reserved_held, "reserved level without reserved flag")
    `FLM_ASSERT(a_busy_level, o_rsp_valid && o_rsp.status == ST_BUSY |-> o_rsp.level_now != LV_EXCL, "busy result reports exclusive")
    // A result out of an empty pipe has passed the request and result registers.
    `FLM_ASSERT(a_rsp_cause, $rose(o_rsp_valid) |-> $past(i_req_valid && o_req_ready, 2), "result word without an accepted request")

endmodule

bind multi_client_file_lock_manager flm_checker u_flm_checker (.*);

/* bench/tb_top.sv */
// Self-checking bench for the five-level file lock manager: directed lock sequences, then
// random traffic checked against a cycle-free model of levels, held bits and readers.
// Depends on flm_pkg and multi_client_file_lock_manager.
`timescale 1ns / 1ps

module tb_top;
    import flm_pkg::*;

    localparam int NUM_CL = DEF_NUM_CLIENTS;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    t_req req       = '0;
    logic rsp_ready = 1'b0;
    logic o_req_ready;
    logic o_rsp_valid;
    t_rsp o_rsp;

    // Model of the lock table
    logic [2:0] lock_levels [NUM_CL];
    logic [3:0] held_mask    = '0;
    logic [3:0] reader_total = '0;

    t_rsp rsp_due [$];
    int   errors      = 0;
    bit   sender_idle = 1'b1;
    bit   recv_idle   = 1'b1;

    multi_client_file_lock_manager #(
        .NUM_CLIENTS(NUM_CL)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req_valid(req_valid),
        .o_req_ready(o_req_ready),
        .i_req      (req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(rsp_ready),
        .o_rsp      (o_rsp)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        for (int i = 0; i < NUM_CL; i++) lock_levels[i] = LV_NONE;
    end

    // Apply one request to the model and return the word the block must answer with.
    function automatic t_rsp predict_lock(input t_req r);
        t_rsp       rsp;
        logic [2:0] cur;
        logic [2:0] nxt;
        logic [1:0] st;
        logic       ok;
        logic       took_pend;
        rsp = '0;
        if (int'(r.client) >= NUM_CL) begin
            rsp.status        = ST_ILLEGAL;
            rsp.level_now     = LV_NONE;
            rsp.reserved_held = held_mask[BIT_RESERVED];
            return rsp;
        end
        cur = lock_levels[r.client];
        nxt = cur;
        st  = ST_OK;
        if (r.operation == OP_RAISE) begin
            if (r.level > LV_EXCL) begin
                st = ST_ILLEGAL;
            end else if (cur >= r.level) begin
                st = ST_OK;
            end else if ((cur == LV_NONE && r.level != LV_SHARED) || r.level == LV_PENDING ||
                         (r.level == LV_RESERVED && cur != LV_SHARED)) begin
                st = ST_ILLEGAL;
            end else begin
                ok        = 1'b1;
                took_pend = 1'b0;
                // entering shared, or climbing from reserved, goes through pending
                if (cur == LV_NONE || (r.level == LV_EXCL && cur == LV_RESERVED)) begin
                    ok = !held_mask[BIT_PENDING];
                    if (ok) held_mask[BIT_PENDING] = 1'b1;
                    took_pend = ok;
                end
                if (r.level == LV_SHARED && ok) begin
                    if (reader_total != RCNT_MAX) reader_total++;
                    held_mask[BIT_SHARED] = 1'b1;
                    nxt = LV_SHARED;
                end
                if (r.level == LV_RESERVED && ok) begin
                    ok = !held_mask[BIT_RESERVED];
                    if (ok) begin
                        held_mask[BIT_RESERVED] = 1'b1;
                        nxt = LV_RESERVED;
                    end
                end
                if (r.level == LV_EXCL && ok) begin
                    // keep pending while waiting on exclusive; reader count is not checked
                    nxt       = LV_PENDING;
                    took_pend = 1'b0;
                    ok        = !held_mask[BIT_EXCL];
                    if (ok) begin
                        held_mask[BIT_EXCL] = 1'b1;
                        nxt = LV_EXCL;
                    end
                end
                if (took_pend && r.level == LV_SHARED) held_mask[BIT_PENDING] = 1'b0;
                st = ok ? ST_OK : ST_BUSY;
            end
        end else begin
            if (r.level > LV_SHARED) begin
                st = ST_ILLEGAL;
            end else if (cur > r.level) begin
                if (cur >= LV_EXCL) held_mask[BIT_EXCL] = 1'b0;
                if (cur >= LV_RESERVED) held_mask[BIT_RESERVED] = 1'b0;
                if (r.level == LV_NONE && cur >= LV_SHARED) begin
                    if (reader_total != 4'd0) reader_total--;
                    if (reader_total == 4'd0) held_mask[BIT_SHARED] = 1'b0;
                end
                if (cur >= LV_PENDING) held_mask[BIT_PENDING] = 1'b0;
                nxt = r.level;
            end
        end
        lock_levels[r.client] = nxt;
        rsp.status        = st;
        rsp.level_now     = nxt;
        rsp.reserved_held = (nxt >= LV_RESERVED) || held_mask[BIT_RESERVED];
        return rsp;
    endfunction

    // Mostly the next legal step for a random client, now and then a raw random word.
    function automatic t_req pick_lock_req();
        t_req       r;
        logic [2:0] cur;
        int         roll;
        if ($urandom_range(0, 6) == 0) begin
            r = 7'($urandom);
            return r;
        end
        r.client = 3'($urandom_range(0, 7));
        cur      = lock_levels[r.client];
        roll     = $urandom_range(0, 5);
        case (cur) inside
            LV_NONE: begin
                r.operation = OP_RAISE;
                r.level     = LV_SHARED;
            end
            LV_SHARED: begin
                r.operation = (roll < 2) ? OP_LOWER : OP_RAISE;
                r.level     = (roll < 2) ? LV_NONE : ((roll < 4) ? LV_RESERVED : LV_EXCL);
            end
            LV_RESERVED, LV_PENDING: begin
                r.operation = (roll < 3) ? OP_RAISE : OP_LOWER;
                r.level     = (roll < 3) ? LV_EXCL : ((roll == 3) ? LV_SHARED : LV_NONE);
            end
            default: begin
                r.operation = OP_LOWER;
                r.level     = (roll < 3) ? LV_SHARED : LV_NONE;
            end
        endcase
        return r;
    endfunction

    // Send one request word; valid stays high into the next call unless it idles.
    task automatic send_lock_req(input t_req r);
        if (sender_idle && $urandom_range(0, 5) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!o_req_ready);
        rsp_due.push_back(predict_lock(r));
    endtask

    task automatic send_fields(input logic [2:0] client, input logic op, input logic [2:0] level);
        t_req r;
        r.client    = client;
        r.operation = op;
        r.level     = level;
        send_lock_req(r);
    endtask

    task automatic drain_rsp();
        req_valid <= 1'b0;
        while (rsp_due.size() != 0) @(posedge clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    task automatic test_climb();
        send_fields(3'd0, OP_RAISE, LV_SHARED);
        send_fields(3'd0, OP_RAISE, LV_SHARED);
        send_fields(3'd0, OP_RAISE, LV_RESERVED);
        send_fields(3'd0, OP_RAISE, LV_EXCL);
        drain_rsp();
    endtask

    task automatic test_contention();
        // client 0 still holds pending from its climb
        send_fields(3'd1, OP_RAISE, LV_SHARED);
        send_fields(3'd0, OP_LOWER, LV_SHARED);
        send_fields(3'd1, OP_RAISE, LV_SHARED);
        send_fields(3'd1, OP_RAISE, LV_RESERVED);
        send_fields(3'd2, OP_RAISE, LV_SHARED);
        send_fields(3'd2, OP_RAISE, LV_RESERVED);
        send_fields(3'd2, OP_RAISE, LV_EXCL);
        send_fields(3'd7, OP_RAISE, LV_SHARED);
        send_fields(3'd1, OP_RAISE, LV_EXCL);
        drain_rsp();
    endtask

    task automatic test_illegal();
        send_fields(3'd3, OP_RAISE, LV_RESERVED);
        send_fields(3'd3, OP_RAISE, LV_PENDING);
        // level codes past exclusive, and lowers above shared
        send_fields(3'd3, OP_RAISE, 3'd7);
        send_fields(3'd0, OP_RAISE, 3'd5);
        send_fields(3'd0, OP_LOWER, LV_RESERVED);
        send_fields(3'd7, OP_LOWER, 3'd7);
        drain_rsp();
    endtask

    task automatic test_lowering();
        send_fields(3'd2, OP_LOWER, LV_NONE);
        send_fields(3'd1, OP_LOWER, LV_NONE);
        send_fields(3'd0, OP_LOWER, LV_NONE);
        send_fields(3'd7, OP_LOWER, LV_NONE);
        send_fields(3'd3, OP_LOWER, LV_NONE);
        send_fields(3'd0, OP_LOWER, LV_SHARED);
        drain_rsp();
    endtask

    task automatic test_random_traffic(input int count);
        for (int i = 0; i < count; i++) send_lock_req(pick_lock_req());
        drain_rsp();
    endtask

    task automatic test_steady_stream(input int count);
        sender_idle = 1'b0;
        recv_idle   = 1'b0;
        for (int i = 0; i < count; i++) send_lock_req(pick_lock_req());
        drain_rsp();
    endtask

    // Result side: check each accepted word, then pick ready for the next cycle.
    initial begin
        t_rsp want;
        int   stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && o_rsp_valid && rsp_ready) begin
                if (rsp_due.size() == 0) begin
                    errors++;
                    $display("%0t: result word with nothing pending, actual status %0d level %0d",
                             $time, o_rsp.status, o_rsp.level_now);
                end else begin
                    want = rsp_due.pop_front();
                    check_field("status", want.status, o_rsp.status);
                    check_field("level_now", want.level_now, o_rsp.level_now);
                    check_field("reserved_held", want.reserved_held, o_rsp.reserved_held);
                end
            end
            if (!rst_n) begin
                rsp_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_ready <= 1'b0;
            end else if (recv_idle && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 9);
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_climb();
        test_contention();
        test_illegal();
        test_lowering();
        test_random_traffic(1200);
        test_steady_stream(300);
        // hold for any stray result word
        repeat (5) @(posedge clk);
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
